FILE: rtl/core/awt_pkg.sv
// Shared types and constants of the address range watchpoint table.
package awt_pkg;

    // Number of table slots. One slot is always kept free, so the table holds
    // at most TABLE_SLOTS - 1 entries.
    localparam int TABLE_SLOTS = 256;
    localparam int CNT_W       = $clog2(TABLE_SLOTS);

    localparam logic [CNT_W-1:0] ENTRY_MAX = CNT_W'(TABLE_SLOTS - 1);

    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 31;
    localparam int MATCH_W  = 8;

    localparam logic [MATCH_W-1:0] MATCH_MAX = '1;

    // Item kinds.
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_ADDED    = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd2;
    localparam logic [1:0] STATUS_MATCHED  = 2'd3;

    // Bit positions in the stored flag field.
    localparam int FLAG_READ_BIT  = 0;
    localparam int FLAG_WRITE_BIT = 1;
    localparam int FLAG_HALT_BIT  = 2;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic              watch_reads;
        logic              watch_writes;
        logic              halt_on_hit;
        logic              access_is_write;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [MATCH_W-1:0] match_count;
        logic               halt_request;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
        logic [2:0]        flags;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: rtl/core/awt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module awt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/address_range_watchpoint_table.sv
// Top level of the address range watchpoint table: sequencer, table memory and comparator.
//
// The block keeps a table of up to TABLE_SLOTS - 1 watch ranges in one RAM.
// An item is taken when start is high and busy is low. An add item is answered
// without raising busy, and the result strobe o_done follows on the next cycle
// with status added or, when the table already holds TABLE_SLOTS - 1 entries,
// status full. A check item on an empty table is answered the same way. A check
// item on a table of N entries walks the table one entry per cycle through the
// RAM's single read port and one shared comparator, with busy high through the
// scan and flush states; the result is registered when the flush state ends.
// Each result is shown for exactly one cycle with o_done high and must be
// captured then, since the receiver cannot hold it off. The result register
// is separate from the sequencer, so a new item may be started in the very
// cycle a result is being shown. No clearing pass is needed after reset: only
// entries below the stored count are read.
module address_range_watchpoint_table
    import awt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_done,
    output t_out_item o_result
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    // Control state.
    t_state           r_state,   n_state;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [CNT_W-1:0] r_idx,     n_idx;
    logic             r_cmp_vld, n_cmp_vld;
    logic             r_done,    n_done;

    // Datapath state.
    logic [ADDR_W-1:0]  r_addr;
    logic               r_is_write;
    logic [MATCH_W-1:0] r_acc,    n_acc;
    logic               r_halt,   n_halt;
    t_out_item          r_result, n_result;

    logic               w_accept;
    logic               w_we;
    t_entry             w_wentry;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry             w_entry;
    logic [ADDR_W-1:0]  w_hi;
    logic               w_need;
    logic               w_hit;
    logic [MATCH_W-1:0] w_acc_next;
    logic               w_halt_next;

    assign w_accept = start && !busy;

    // Entry as stored for an add item.
    always_comb begin
        w_wentry.start  = i_item.address;
        w_wentry.length = i_item.length;
        w_wentry.flags  = '0;
        w_wentry.flags[FLAG_READ_BIT]  = i_item.watch_reads;
        w_wentry.flags[FLAG_WRITE_BIT] = i_item.watch_writes;
        w_wentry.flags[FLAG_HALT_BIT]  = i_item.halt_on_hit;
    end

    awt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count),
        .i_wdata (w_wentry),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // The shared comparator sees one entry per cycle, in the cycle after its read
    // was issued. The range end wraps modulo 2^32, so a range that wraps past
    // zero or has zero length can never contain the address.
    assign w_entry = t_entry'(w_rdata);
    assign w_hi    = w_entry.start + ADDR_W'(w_entry.length);
    assign w_need  = r_is_write ? w_entry.flags[FLAG_WRITE_BIT]
                                : w_entry.flags[FLAG_READ_BIT];
    assign w_hit   = r_cmp_vld && (r_addr >= w_entry.start) && (r_addr < w_hi) && w_need;

    // The match count saturates at its maximum.
    assign w_acc_next  = (w_hit && (r_acc != MATCH_MAX)) ? r_acc + MATCH_W'(1) : r_acc;
    assign w_halt_next = r_halt | (w_hit & w_entry.flags[FLAG_HALT_BIT]);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_vld = 1'b0;
        n_done    = 1'b0;
        n_acc     = r_acc;
        n_halt    = r_halt;
        n_result  = r_result;
        w_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_result.match_count  = '0;
                    n_result.halt_request = 1'b0;
                    if (i_item.kind == KIND_ADD) begin
                        n_done = 1'b1;
                        if (r_count >= ENTRY_MAX) begin
                            n_result.status = STATUS_FULL;
                        end else begin
                            n_result.status = STATUS_ADDED;
                            w_we            = 1'b1;
                            n_count         = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_done          = 1'b1;
                        n_result.status = STATUS_NO_MATCH;
                    end else begin
                        n_state = S_SCAN;
                        n_idx   = '0;
                        n_acc   = '0;
                        n_halt  = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                n_cmp_vld = 1'b1;
                n_acc     = w_acc_next;
                n_halt    = w_halt_next;
                if (r_idx + CNT_W'(1) == r_count) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_FLUSH: begin
                // The last entry's read data is compared in this cycle.
                n_done                = 1'b1;
                n_acc                 = w_acc_next;
                n_halt                = w_halt_next;
                n_result.match_count  = w_acc_next;
                n_result.halt_request = w_halt_next;
                n_result.status       = (w_acc_next != '0) ? STATUS_MATCHED
                                                           : STATUS_NO_MATCH;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr     <= i_item.address;
            r_is_write <= i_item.access_is_write;
        end
        r_acc    <= n_acc;
        r_halt   <= n_halt;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    // The stored count never reaches the reserved free slot.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ENTRY_MAX)
        else $error("entry count beyond table capacity");

    // The scan index stays inside the stored entries.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_count))
        else $error("scan index past stored entries");

    // An add item is answered on the next cycle without raising busy.
    a_add_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.kind == KIND_ADD)) |=> (o_done && !busy))
        else $error("add item not answered in one cycle");

    // Matched status goes with a nonzero count, and a halt only with a match.
    a_status_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (((o_result.status == STATUS_MATCHED) == (o_result.match_count != '0))
                    && (!o_result.halt_request || (o_result.status == STATUS_MATCHED))))
        else $error("result status disagrees with count or halt");

    // A count is only modified by an accepted add.
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> ($past(w_accept) && ($past(i_item.kind) == KIND_ADD)))
        else $error("entry count changed without an add item");
`endif

endmodule
